### sv/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPLY(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

`endif

### sv/smzrm_pkg.sv
// Shared types and constants of the zone read master.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package smzrm_pkg;

   localparam int DLY_BITS   = 12;
   localparam int DLY_CALC_W = (DLY_BITS >= 12) ? DLY_BITS + 1 : 13;
   localparam logic [DLY_CALC_W-1:0] DLY_MAX = DLY_CALC_W'((1 << DLY_BITS) - 1);

   // bus delays in microseconds
   localparam logic [3:0] US_BIT  = 4'd2;
   localparam logic [3:0] US_LONG = 4'd10;

   // register reset values
   localparam logic [7:0] TPM_RESET   = 8'd1;
   localparam logic [7:0] POLL_RESET  = 8'd250;
   localparam logic [7:0] CMD_RESET   = 8'hB6;
   localparam logic [7:0] ADDRH_RESET = 8'h00;

   // register indexes
   localparam logic [1:0] CSR_TPM   = 2'd0;
   localparam logic [1:0] CSR_POLL  = 2'd1;
   localparam logic [1:0] CSR_CMD   = 2'd2;
   localparam logic [1:0] CSR_ADDRH = 2'd3;

   typedef struct packed {
      logic [7:0] ticks_per_us;
      logic [7:0] poll_limit;
      logic [7:0] command_byte;
      logic [7:0] address_high_byte;
   } cfg_type;

   typedef struct packed {
      logic       clock_line;
      logic       data_drive_level;
      logic       data_drive_enable;
      logic       busy_res;
      logic       byte_valid;
      logic [7:0] read_byte;
      logic       last_byte;
      logic       transfer_done;
      logic       transfer_status;
   } rsp_type;

endpackage

### sv/smzrm_core.sv
// Bus sequencer of the zone read master: one step per accepted item.
// Depends on smzrm_pkg for the configuration and result types.
`timescale 1ns / 1ps

module smzrm_core import smzrm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       start_request,
   input  logic [7:0] zone_address,
   input  logic [7:0] byte_count,
   input  logic       sda_sample,
   input  cfg_type    cfg,
   output rsp_type    result
);

   typedef enum logic [17:0] {
      PH_IDLE      = 18'h00001,
      PH_START_LOW = 18'h00002,
      PH_START_CLK = 18'h00004,
      PH_WR_BIT    = 18'h00008,
      PH_WR_HIGH   = 18'h00010,
      PH_WR_LOW    = 18'h00020,
      PH_ACK_REL   = 18'h00040,
      PH_ACK_POLL  = 18'h00080,
      PH_ACK_END   = 18'h00100,
      PH_RD_BEGIN  = 18'h00200,
      PH_RD_LOW    = 18'h00400,
      PH_RD_HIGH   = 18'h00800,
      PH_RD_END    = 18'h01000,
      PH_AO_HIGH   = 18'h02000,
      PH_AO_LOW    = 18'h04000,
      PH_STOP      = 18'h08000,
      PH_STOP_HIGH = 18'h10000,
      PH_STOP_END  = 18'h20000
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [1:0]          hdr_ff, hdr_in;
   logic [3:0]          bit_ff, bit_in;
   logic [7:0]          shift_ff, shift_in;
   logic [DLY_BITS-1:0] dly_ff, dly_in;
   logic [7:0]          poll_ff, poll_in;
   logic [7:0]          left_ff, left_in;
   logic [7:0]          addr_ff, addr_in;
   logic [7:0]          cnt_ff, cnt_in;
   logic                clk_ff, clk_in;
   logic                dat_ff, dat_in;
   logic                drv_ff, drv_in;
   logic                fail_ff, fail_in;
   logic                go_stop, go_read;
   logic [3:0]          bit_next;

   // load value of the delay counter for a wait of us microseconds
   function automatic logic [DLY_BITS-1:0] dly_load(input logic [3:0] us,
                                                    input logic [7:0] tpm);
      logic [DLY_CALC_W-1:0] prod;
      prod = DLY_CALC_W'(us) * DLY_CALC_W'(tpm);
      if (prod > DLY_MAX) begin
         prod = DLY_MAX;
      end
      if (prod != '0) begin
         prod = prod - 1'b1;
      end
      return prod[DLY_BITS-1:0];
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [1:0] idx, input cfg_type c,
                                           input logic [7:0] addr, input logic [7:0] cnt);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = c.command_byte;
         2'd1:    b = c.address_high_byte;
         2'd2:    b = addr;
         default: b = cnt;
      endcase
      return b;
   endfunction

   assign bit_next = bit_ff + 4'd1;

   always_comb begin
      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      dly_in   = dly_ff;
      poll_in  = poll_ff;
      left_in  = left_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      clk_in   = clk_ff;
      dat_in   = dat_ff;
      drv_in   = drv_ff;
      fail_in  = fail_ff;
      go_stop  = 1'b0;
      go_read  = 1'b0;
      result   = '0;

      if (phase_ff != PH_IDLE && dly_ff != '0) begin
         dly_in = dly_ff - 1'b1;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (start_request) begin
                  addr_in  = zone_address;
                  cnt_in   = byte_count;
                  left_in  = byte_count;
                  hdr_in   = 2'd0;
                  fail_in  = 1'b0;
                  drv_in   = 1'b1;
                  clk_in   = 1'b1;
                  dat_in   = 1'b1;
                  dly_in   = dly_load(US_LONG, cfg.ticks_per_us);
                  phase_in = PH_START_LOW;
               end
            end
            PH_START_LOW: begin
               dat_in   = 1'b0;
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               phase_in = PH_START_CLK;
            end
            PH_START_CLK: begin
               clk_in   = 1'b0;
               shift_in = hdr_byte(hdr_ff, cfg, addr_ff, cnt_ff);
               bit_in   = 4'd0;
               dly_in   = '0;
               phase_in = PH_WR_BIT;
            end
            PH_WR_BIT: begin
               drv_in   = 1'b1;
               clk_in   = 1'b0;
               dat_in   = shift_ff[7];
               shift_in = {shift_ff[6:0], 1'b0};
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               phase_in = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
               clk_in   = 1'b1;
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               phase_in = PH_WR_LOW;
            end
            PH_WR_LOW: begin
               clk_in   = 1'b0;
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               bit_in   = bit_next;
               phase_in = (bit_next >= 4'd8) ? PH_ACK_REL : PH_WR_BIT;
            end
            PH_ACK_REL: begin
               drv_in   = 1'b0;
               clk_in   = 1'b1;
               dat_in   = 1'b1;
               poll_in  = 8'd0;
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               phase_in = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
               if (!sda_sample) begin
                  dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
                  phase_in = PH_ACK_END;
               end else if (poll_ff >= cfg.poll_limit) begin
                  fail_in = 1'b1;
                  go_stop = 1'b1;
               end else begin
                  poll_in = poll_ff + 8'd1;
                  dly_in  = dly_load(US_BIT, cfg.ticks_per_us);
               end
            end
            PH_ACK_END: begin
               clk_in = 1'b0;
               if (hdr_ff == 2'd3) begin
                  go_read = 1'b1;
               end else begin
                  hdr_in   = hdr_ff + 2'd1;
                  shift_in = hdr_byte(hdr_ff + 2'd1, cfg, addr_ff, cnt_ff);
                  bit_in   = 4'd0;
                  dly_in   = '0;
                  phase_in = PH_WR_BIT;
               end
            end
            PH_RD_BEGIN: begin
               go_read = 1'b1;
            end
            PH_RD_LOW: begin
               clk_in   = 1'b0;
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               phase_in = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
               clk_in   = 1'b1;
               shift_in = {shift_ff[6:0], sda_sample};
               bit_in   = bit_next;
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               phase_in = (bit_next >= 4'd8) ? PH_RD_END : PH_RD_LOW;
            end
            PH_RD_END: begin
               clk_in   = 1'b0;
               drv_in   = 1'b1;
               dat_in   = (left_ff == 8'd1);
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               phase_in = PH_AO_HIGH;
            end
            PH_AO_HIGH: begin
               clk_in   = 1'b1;
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               phase_in = PH_AO_LOW;
            end
            PH_AO_LOW: begin
               clk_in            = 1'b0;
               result.byte_valid = 1'b1;
               result.read_byte  = shift_ff;
               result.last_byte  = (left_ff == 8'd1);
               if (left_ff != 8'd0) begin
                  left_in = left_ff - 8'd1;
               end
               dly_in   = '0;
               phase_in = PH_RD_BEGIN;
            end
            PH_STOP: begin
               go_stop = 1'b1;
            end
            PH_STOP_HIGH: begin
               clk_in   = 1'b1;
               dly_in   = dly_load(US_BIT, cfg.ticks_per_us);
               phase_in = PH_STOP_END;
            end
            PH_STOP_END: begin
               dat_in                 = 1'b1;
               result.transfer_done   = 1'b1;
               result.transfer_status = fail_ff;
               dly_in                 = '0;
               phase_in               = PH_IDLE;
            end
            default: begin
               dly_in   = '0;
               phase_in = PH_IDLE;
            end
         endcase

         // next byte or, with none left, the stop
         if (go_read) begin
            if (left_ff == 8'd0) begin
               go_stop = 1'b1;
            end else begin
               drv_in   = 1'b0;
               bit_in   = 4'd0;
               shift_in = 8'd0;
               dly_in   = dly_load(US_LONG, cfg.ticks_per_us);
               phase_in = PH_RD_LOW;
            end
         end
         if (go_stop) begin
            drv_in   = 1'b1;
            clk_in   = 1'b0;
            dat_in   = 1'b0;
            dly_in   = dly_load(US_LONG, cfg.ticks_per_us);
            phase_in = PH_STOP_HIGH;
         end
      end

      result.clock_line        = clk_in;
      result.data_drive_level  = dat_in;
      result.data_drive_enable = drv_in;
      result.busy_res          = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hdr_ff   <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         dly_ff   <= '0;
         poll_ff  <= '0;
         left_ff  <= '0;
         addr_ff  <= '0;
         cnt_ff   <= '0;
         clk_ff   <= 1'b1;
         dat_ff   <= 1'b1;
         drv_ff   <= 1'b1;
         fail_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         dly_ff   <= dly_in;
         poll_ff  <= poll_in;
         left_ff  <= left_in;
         addr_ff  <= addr_in;
         cnt_ff   <= cnt_in;
         clk_ff   <= clk_in;
         dat_ff   <= dat_in;
         drv_ff   <= drv_in;
         fail_ff  <= fail_in;
      end
   end

endmodule

### sv/smzrm_obuf.sv
// Result register with one skid stage of the zone read master.
// Depends on smzrm_pkg for the result type.
`timescale 1ns / 1ps

module smzrm_obuf import smzrm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff;
   logic    push, pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= in_data;
         end else begin
            skid_ff <= in_data;
         end
      end
   end

endmodule

### sv/secure_memory_zone_read_master.sv
// Top level of the zone read master: register file, sequencer, result buffer.
// Depends on smzrm_pkg, smzrm_core, smzrm_obuf and assert_macros.svh.
//
//   channel   direction  handshake               carries
//   req_      in         req_valid / req_ready   one bus tick: start, address, count, data sample
//   rsp_      out        rsp_valid / rsp_ready   bus pins, received byte and end status
//   csr       in/out     psel, penable, pready   four 8-bit registers at byte addresses 0..12
//
// One item per cycle while req_ready is high; its result lands in the output or skid register.
// The sequencer state steps only on an accepted item, so one item is one bus tick.
// A stalled result side holds one result in the output register and one in the skid
// stage; req_ready drops only when both are full.
// Reset is synchronous; there is no clearing pass.
`timescale 1ns / 1ps

module secure_memory_zone_read_master import smzrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_start_request,
   input  logic [7:0]  req_zone_address,
   input  logic [7:0]  req_byte_count,
   input  logic        req_sda_sample,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_clock_line,
   output logic        rsp_data_drive_level,
   output logic        rsp_data_drive_enable,
   output logic        rsp_busy_res,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_last_byte,
   output logic        rsp_transfer_done,
   output logic        rsp_transfer_status,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg_ff;
   rsp_type    step_rsp, buf_rsp;
   logic       step;
   logic       csr_wr;
   logic [1:0] csr_idx;

   // register port: no wait states, word index from the upper address bits
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_us      <= TPM_RESET;
         cfg_ff.poll_limit        <= POLL_RESET;
         cfg_ff.command_byte      <= CMD_RESET;
         cfg_ff.address_high_byte <= ADDRH_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_TPM:   cfg_ff.ticks_per_us      <= pwdata[7:0];
            CSR_POLL:  cfg_ff.poll_limit        <= pwdata[7:0];
            CSR_CMD:   cfg_ff.command_byte      <= pwdata[7:0];
            CSR_ADDRH: cfg_ff.address_high_byte <= pwdata[7:0];
            default:   cfg_ff.ticks_per_us      <= cfg_ff.ticks_per_us;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_TPM:   prdata = {24'd0, cfg_ff.ticks_per_us};
         CSR_POLL:  prdata = {24'd0, cfg_ff.poll_limit};
         CSR_CMD:   prdata = {24'd0, cfg_ff.command_byte};
         CSR_ADDRH: prdata = {24'd0, cfg_ff.address_high_byte};
         default:   prdata = '0;
      endcase
   end

   // advance the bus sequencer on every accepted item
   assign step = req_valid && req_ready;

   smzrm_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .start_request (req_start_request),
      .zone_address  (req_zone_address),
      .byte_count    (req_byte_count),
      .sda_sample    (req_sda_sample),
      .cfg           (cfg_ff),
      .result        (step_rsp)
   );

   // hold the result until the far side takes it
   smzrm_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (step_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (buf_rsp)
   );

   assign rsp_clock_line        = buf_rsp.clock_line;
   assign rsp_data_drive_level  = buf_rsp.data_drive_level;
   assign rsp_data_drive_enable = buf_rsp.data_drive_enable;
   assign rsp_busy_res          = buf_rsp.busy_res;
   assign rsp_byte_valid        = buf_rsp.byte_valid;
   assign rsp_read_byte         = buf_rsp.read_byte;
   assign rsp_last_byte         = buf_rsp.last_byte;
   assign rsp_transfer_done     = buf_rsp.transfer_done;
   assign rsp_transfer_status   = buf_rsp.transfer_status;

   `include "assert_macros.svh"

   // a back-pressured input means both buffer slots are full
   `ASSERT_IMPLY(a_stall_full, !req_ready, rsp_valid, "input stalled with empty result register")
   // a received byte and the end of the transfer never share a tick
   `ASSERT_CLK(a_byte_not_done, !(rsp_valid && rsp_byte_valid && rsp_transfer_done), "byte on done tick")
   // the done tick already reports the bus as free
   `ASSERT_IMPLY(a_done_idle, rsp_valid && rsp_transfer_done, !rsp_busy_res, "busy on done tick")
   // a fail status only comes with the done pulse
   `ASSERT_IMPLY(a_status_done, rsp_valid && rsp_transfer_status, rsp_transfer_done, "status without done")

endmodule
